// ----- src/tpt_pkg.sv -----
// Package of shared types and constants for the tag permission table.
package tpt_pkg;

  localparam int TagW   = 32;
  localparam int MaskW  = 8;
  localparam int ModeW  = 3;
  localparam int SlotW  = 8;
  localparam int StatW  = 3;
  localparam int EntryW = TagW + MaskW;

  localparam logic [TagW-1:0]  EmptyTag  = 32'hFFFF_FFFF;
  localparam logic [MaskW-1:0] EmptyMask = 8'hFF;
  localparam logic [TagW-1:0]  ZeroTag   = 32'h0000_0000;

  typedef enum logic [ModeW-1:0] {
    MODE_LOOKUP = 3'd0,
    MODE_UPSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_RESERVED  = 3'd4,
    STAT_UNUSED    = 3'd5
  } stat_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [TagW-1:0]  tag;
    logic [MaskW-1:0] mask;
    logic [SlotW-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot_index;
    logic [TagW-1:0]  tag_out;
    logic [MaskW-1:0] mask_out;
  } rsp_t;

endpackage

// ----- src/tpt_chan_if.sv -----
// Valid/ready channel interface carrying one payload beat.
interface tpt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/tpt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module tpt_ram #(
  parameter int W = 40,
  parameter int D = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tag_permission_table_unit.sv -----
// Top level of the tag permission table: slot store in RAM and its scan sequencer.
//
// The table holds SLOTS slots of a 32-bit tag and an 8-bit permission mask in
// one RAM, and every operation walks that RAM through its single read port, one
// slot per cycle. Lookup, upsert and delete scan the slots from the request beat
// to the result, stopping early when the tag matches; clear all writes every
// slot; read slot reads the one slot named; a reserved tag, an out-of-range slot
// or an undefined mode answers without a scan. After reset a clearing pass
// empties the RAM, and no request is taken until it ends. A new request beat is
// taken while the previous result beat still waits.
module tag_permission_table_unit #(
  parameter int SLOTS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  tpt_chan_if.sink   req_i,
  tpt_chan_if.source rsp_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(SLOTS - 1);

  tpt_pkg::state_e state_q, state_d;

  logic [tpt_pkg::ModeW-1:0] mode_q;
  logic [tpt_pkg::TagW-1:0]  tag_q;
  logic [tpt_pkg::MaskW-1:0] mask_q;
  logic [tpt_pkg::SlotW-1:0] slot_q;
  logic                      lat;

  logic [AW-1:0] idx_q, idx_d;
  logic          efound_q, efound_d;
  logic [AW-1:0] eidx_q, eidx_d;

  tpt_pkg::rsp_t res_q, res_d;
  tpt_pkg::rsp_t out_q;
  logic          out_vld_q;
  logic          out_load;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tpt_pkg::EntryW-1:0] wdata;
  logic [AW-1:0]              raddr;
  logic [tpt_pkg::EntryW-1:0] rdata;

  logic [tpt_pkg::TagW-1:0]  cur_tag;
  logic [tpt_pkg::MaskW-1:0] cur_mask;
  logic                      cur_empty;
  logic                      hit;
  logic                      last;
  logic                      in_reserved;
  logic [31:0]               in_slot_w;
  logic [AW-1:0]             fill_idx;

  function automatic logic [tpt_pkg::SlotW-1:0] low8(logic [AW-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[tpt_pkg::SlotW-1:0];
  endfunction

  function automatic tpt_pkg::rsp_t mk_rsp(tpt_pkg::stat_e st);
    tpt_pkg::rsp_t r;
    r.status     = st;
    r.slot_index = '0;
    r.tag_out    = '0;
    r.mask_out   = '0;
    return r;
  endfunction

  tpt_ram #(
    .W(tpt_pkg::EntryW),
    .D(SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cur_tag     = rdata[tpt_pkg::EntryW-1:tpt_pkg::MaskW];
  assign cur_mask    = rdata[tpt_pkg::MaskW-1:0];
  assign cur_empty   = (cur_tag == tpt_pkg::EmptyTag) && (cur_mask == tpt_pkg::EmptyMask);
  assign hit         = (cur_tag == tag_q);
  assign last        = (idx_q == LastIdx);
  assign in_reserved = (req_i.payload.tag == tpt_pkg::ZeroTag) ||
                       (req_i.payload.tag == tpt_pkg::EmptyTag);
  assign in_slot_w   = 32'(req_i.payload.slot);
  assign fill_idx    = efound_q ? eidx_q : idx_q;

  assign req_i.ready   = (state_q == tpt_pkg::ST_IDLE);
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    efound_d = efound_q;
    eidx_d   = eidx_q;
    res_d    = res_q;
    lat      = 1'b0;
    out_load = 1'b0;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = {tpt_pkg::EmptyTag, tpt_pkg::EmptyMask};
    raddr    = idx_q;

    unique case (state_q)
      tpt_pkg::ST_INIT, tpt_pkg::ST_CLEAR: begin
        we = 1'b1;
        if (last) begin
          if (state_q == tpt_pkg::ST_CLEAR) begin
            res_d   = mk_rsp(tpt_pkg::STAT_OK);
            state_d = tpt_pkg::ST_DONE;
          end else begin
            state_d = tpt_pkg::ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      tpt_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          lat      = 1'b1;
          idx_d    = '0;
          efound_d = 1'b0;
          raddr    = '0;
          unique case (req_i.payload.mode)
            tpt_pkg::MODE_LOOKUP, tpt_pkg::MODE_DELETE: begin
              if (in_reserved) begin
                res_d   = mk_rsp(tpt_pkg::STAT_NOT_FOUND);
                state_d = tpt_pkg::ST_DONE;
              end else begin
                state_d = tpt_pkg::ST_SCAN;
              end
            end
            tpt_pkg::MODE_UPSERT: begin
              if (in_reserved) begin
                res_d   = mk_rsp(tpt_pkg::STAT_RESERVED);
                state_d = tpt_pkg::ST_DONE;
              end else begin
                state_d = tpt_pkg::ST_SCAN;
              end
            end
            tpt_pkg::MODE_CLEAR: begin
              state_d = tpt_pkg::ST_CLEAR;
            end
            tpt_pkg::MODE_READ: begin
              if (in_slot_w < SLOTS) begin
                raddr   = in_slot_w[AW-1:0];
                state_d = tpt_pkg::ST_READ;
              end else begin
                res_d   = mk_rsp(tpt_pkg::STAT_NOT_FOUND);
                state_d = tpt_pkg::ST_DONE;
              end
            end
            default: begin
              res_d   = mk_rsp(tpt_pkg::STAT_NOT_FOUND);
              state_d = tpt_pkg::ST_DONE;
            end
          endcase
        end
      end

      tpt_pkg::ST_SCAN: begin
        if (hit) begin
          res_d            = mk_rsp(tpt_pkg::STAT_OK);
          res_d.slot_index = low8(idx_q);
          state_d          = tpt_pkg::ST_DONE;
          priority if (mode_q == tpt_pkg::MODE_UPSERT) begin
            we             = 1'b1;
            wdata          = {tag_q, mask_q};
            res_d.mask_out = mask_q;
          end else if (mode_q == tpt_pkg::MODE_DELETE) begin
            we             = 1'b1;
            res_d.mask_out = cur_mask;
          end else begin
            res_d.mask_out = cur_mask;
          end
        end else if (last) begin
          state_d = tpt_pkg::ST_DONE;
          if (mode_q == tpt_pkg::MODE_UPSERT) begin
            if (efound_q || cur_empty) begin
              we               = 1'b1;
              waddr            = fill_idx;
              wdata            = {tag_q, mask_q};
              res_d            = mk_rsp(tpt_pkg::STAT_ADDED);
              res_d.slot_index = low8(fill_idx);
              res_d.mask_out   = mask_q;
            end else begin
              res_d = mk_rsp(tpt_pkg::STAT_FULL);
            end
          end else begin
            res_d = mk_rsp(tpt_pkg::STAT_NOT_FOUND);
          end
        end else begin
          if (cur_empty && !efound_q) begin
            efound_d = 1'b1;
            eidx_d   = idx_q;
          end
          idx_d = idx_q + 1'b1;
          raddr = idx_q + 1'b1;
        end
      end

      tpt_pkg::ST_READ: begin
        if (cur_empty) begin
          res_d = mk_rsp(tpt_pkg::STAT_UNUSED);
        end else begin
          res_d          = mk_rsp(tpt_pkg::STAT_OK);
          res_d.tag_out  = cur_tag;
          res_d.mask_out = cur_mask;
        end
        res_d.slot_index = slot_q;
        state_d          = tpt_pkg::ST_DONE;
      end

      tpt_pkg::ST_DONE: begin
        // The result moves to the output register once that register is free.
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = tpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tpt_pkg::ST_INIT;
      idx_q     <= '0;
      efound_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      efound_q <= efound_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lat) begin
      mode_q <= req_i.payload.mode;
      tag_q  <= req_i.payload.tag;
      mask_q <= req_i.payload.mask;
      slot_q <= req_i.payload.slot;
    end
    eidx_q <= eidx_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the tag permission table: directed, table-full and random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int ModeW = tpt_pkg::ModeW;
  localparam int TagW  = tpt_pkg::TagW;
  localparam int MaskW = tpt_pkg::MaskW;
  localparam int SlotW = tpt_pkg::SlotW;

  localparam int NumSlots   = 256;
  localparam int StallLimit = 20 * (NumSlots + 4);
  localparam int RandomOps  = 110;
  localparam int PoolSize   = 48;

  localparam logic [ModeW-1:0] ModeFirstUnused = 3'd5;
  localparam logic [ModeW-1:0] ModeLastUnused  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  tpt_chan_if #(.T(tpt_pkg::req_t)) req_if ();
  tpt_chan_if #(.T(tpt_pkg::rsp_t)) rsp_if ();

  tag_permission_table_unit #(
    .SLOTS(NumSlots)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the slot store.
  logic [TagW-1:0]  tag_table  [NumSlots];
  logic [MaskW-1:0] mask_table [NumSlots];

  tpt_pkg::rsp_t pending_answers [$];
  tpt_pkg::rsp_t next_answer;
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  bit            no_stall       = 1'b0;

  function automatic void empty_table();
    for (int s = 0; s < NumSlots; s++) begin
      tag_table[s]  = tpt_pkg::EmptyTag;
      mask_table[s] = tpt_pkg::EmptyMask;
    end
  endfunction

  // Applies one operation to the shadow table and returns the answer it must produce.
  function automatic tpt_pkg::rsp_t apply_table_op(input tpt_pkg::req_t r);
    tpt_pkg::rsp_t a;
    int            hit;
    int            free;
    bit            reserved;
    a        = '0;
    a.status = tpt_pkg::STAT_NOT_FOUND;
    hit      = -1;
    free     = -1;
    reserved = (r.tag == tpt_pkg::ZeroTag) || (r.tag == tpt_pkg::EmptyTag);
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (!reserved && tag_table[s] == r.tag) hit = s;
      if (tag_table[s] == tpt_pkg::EmptyTag && mask_table[s] == tpt_pkg::EmptyMask) free = s;
    end
    unique case (r.mode)
      tpt_pkg::MODE_LOOKUP: begin
        if (hit >= 0) begin
          a.status     = tpt_pkg::STAT_OK;
          a.slot_index = SlotW'(hit);
          a.mask_out   = mask_table[hit];
        end
      end
      tpt_pkg::MODE_UPSERT: begin
        if (reserved) begin
          a.status = tpt_pkg::STAT_RESERVED;
        end else if (hit >= 0) begin
          mask_table[hit] = r.mask;
          a.status        = tpt_pkg::STAT_OK;
          a.slot_index    = SlotW'(hit);
          a.mask_out      = r.mask;
        end else if (free >= 0) begin
          tag_table[free]  = r.tag;
          mask_table[free] = r.mask;
          a.status         = tpt_pkg::STAT_ADDED;
          a.slot_index     = SlotW'(free);
          a.mask_out       = r.mask;
        end else begin
          a.status = tpt_pkg::STAT_FULL;
        end
      end
      tpt_pkg::MODE_DELETE: begin
        if (hit >= 0) begin
          a.mask_out      = mask_table[hit];
          tag_table[hit]  = tpt_pkg::EmptyTag;
          mask_table[hit] = tpt_pkg::EmptyMask;
          a.status        = tpt_pkg::STAT_OK;
          a.slot_index    = SlotW'(hit);
        end
      end
      tpt_pkg::MODE_CLEAR: begin
        empty_table();
        a.status = tpt_pkg::STAT_OK;
      end
      tpt_pkg::MODE_READ: begin
        if (int'(r.slot) < NumSlots) begin
          a.slot_index = r.slot;
          if (tag_table[r.slot] == tpt_pkg::EmptyTag &&
              mask_table[r.slot] == tpt_pkg::EmptyMask) begin
            a.status = tpt_pkg::STAT_UNUSED;
          end else begin
            a.status   = tpt_pkg::STAT_OK;
            a.tag_out  = tag_table[r.slot];
            a.mask_out = mask_table[r.slot];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Drives one request beat, holds it until accepted and records the answer it implies.
  task automatic send_op(input logic [ModeW-1:0] mode, input logic [TagW-1:0] tag,
                         input logic [MaskW-1:0] mask, input logic [SlotW-1:0] slot);
    tpt_pkg::req_t r;
    r.mode = mode;
    r.tag  = tag;
    r.mask = mask;
    r.slot = slot;
    @(negedge clk_i);
    while (!no_stall && $urandom_range(0, 99) < 10) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_answers.push_back(apply_table_op(r));
  endtask

  task automatic test_empty_table();
    send_op(tpt_pkg::MODE_LOOKUP, 32'h1357_9BDF, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_LOOKUP, tpt_pkg::ZeroTag, 8'h00, 8'h00);
    // Empty slots hold the all-ones tag, yet it must never match.
    send_op(tpt_pkg::MODE_LOOKUP, tpt_pkg::EmptyTag, 8'hFF, 8'hFF);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'(NumSlots - 1));
    send_op(tpt_pkg::MODE_DELETE, 32'h2468_ACE0, 8'h00, 8'h00);
    for (int m = ModeFirstUnused; m <= ModeLastUnused; m++) begin
      send_op(ModeW'(m), $urandom, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_basic_ops();
    logic [TagW-1:0] tag_a;
    logic [TagW-1:0] tag_b;
    logic [TagW-1:0] tag_c;
    tag_a = 32'h0000_0001;
    tag_b = 32'hFFFF_FFFE;
    tag_c = 32'h8000_0000;
    send_op(tpt_pkg::MODE_UPSERT, tpt_pkg::ZeroTag, 8'h12, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, tpt_pkg::EmptyTag, 8'h34, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, tag_a, 8'h00, 8'h00);
    // A real tag with an all-ones mask is a live slot, not an empty one.
    send_op(tpt_pkg::MODE_UPSERT, tag_b, 8'hFF, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, tag_a, 8'h5A, 8'h00);
    send_op(tpt_pkg::MODE_LOOKUP, tag_a, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_LOOKUP, tag_b, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'h01);
    send_op(tpt_pkg::MODE_DELETE, tag_a, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_LOOKUP, tag_a, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, tag_c, 8'hA5, 8'h00);
    send_op(tpt_pkg::MODE_LOOKUP, tpt_pkg::EmptyTag, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_CLEAR, tag_b, 8'hFF, 8'hFF);
    send_op(tpt_pkg::MODE_LOOKUP, tag_b, 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'h01);
  endtask

  task automatic test_full_table();
    logic [TagW-1:0] fill_tags [NumSlots];
    logic [TagW-1:0] extra_tag;
    // The low byte keeps the fill tags distinct; the upper bits never make them reserved.
    extra_tag = {24'hFF_FFFF, 8'h00};
    for (int i = 0; i < NumSlots; i++) begin
      fill_tags[i] = {24'($urandom_range(1, 24'hFF_FFFE)), 8'(i)};
      send_op(tpt_pkg::MODE_UPSERT, fill_tags[i], 8'($urandom), 8'($urandom));
    end
    send_op(tpt_pkg::MODE_UPSERT, extra_tag, 8'h77, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, fill_tags[NumSlots - 1], 8'h3C, 8'h00);
    send_op(tpt_pkg::MODE_LOOKUP, fill_tags[NumSlots - 1], 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_READ, 32'h0, 8'h00, 8'(NumSlots - 1));
    send_op(tpt_pkg::MODE_DELETE, fill_tags[NumSlots / 2], 8'h00, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, extra_tag, 8'h77, 8'h00);
    send_op(tpt_pkg::MODE_UPSERT, extra_tag ^ 32'h1, 8'h88, 8'h00);
    send_op(tpt_pkg::MODE_CLEAR, 32'h0, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(input int count);
    logic [TagW-1:0]  tag_pool [PoolSize];
    logic [ModeW-1:0] mode;
    logic [TagW-1:0]  tag;
    int               pick;
    // A small pool of tags keeps hits, updates and deletes frequent.
    for (int i = 0; i < PoolSize; i++) begin
      do tag_pool[i] = $urandom;
      while (tag_pool[i] == tpt_pkg::ZeroTag || tag_pool[i] == tpt_pkg::EmptyTag);
    end
    for (int n = 0; n < count; n++) begin
      no_stall = (n >= count / 3) && (n < 2 * count / 3);
      pick = $urandom_range(0, 99);
      if (pick < 30)      mode = tpt_pkg::MODE_UPSERT;
      else if (pick < 56) mode = tpt_pkg::MODE_LOOKUP;
      else if (pick < 73) mode = tpt_pkg::MODE_DELETE;
      else if (pick < 94) mode = tpt_pkg::MODE_READ;
      else if (pick < 96) mode = tpt_pkg::MODE_CLEAR;
      else                mode = ModeW'($urandom_range(ModeFirstUnused, ModeLastUnused));
      pick = $urandom_range(0, 99);
      if (pick < 85)      tag = tag_pool[$urandom_range(0, PoolSize - 1)];
      else if (pick < 95) tag = $urandom;
      else if (pick < 97) tag = tpt_pkg::ZeroTag;
      else                tag = tpt_pkg::EmptyTag;
      send_op(mode, tag, 8'($urandom),
              ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, PoolSize - 1)) : 8'($urandom));
    end
    no_stall = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every accepted result beat is matched against the oldest answer.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %0h",
                 $time, rsp_if.payload);
        mismatch_count++;
      end else begin
        next_answer = pending_answers.pop_front();
        compare_field("status", 32'(next_answer.status), 32'(rsp_if.payload.status));
        compare_field("slot_index", 32'(next_answer.slot_index),
                      32'(rsp_if.payload.slot_index));
        compare_field("tag_out", next_answer.tag_out, rsp_if.payload.tag_out);
        compare_field("mask_out", 32'(next_answer.mask_out), 32'(rsp_if.payload.mask_out));
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, StallLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= no_stall || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    empty_table();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_random_traffic(RandomOps);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (NumSlots + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
